/* design/rifd_pkg.sv */
// ----------------------------------------------------------------------------
// rifd_pkg
// Types, codes and per-kind tables shared by the instruction field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rifd_pkg;

   // transaction payloads
   typedef struct packed {
      logic [31:0] instruction_word;
      logic [31:0] instruction_address;
   } req_type;

   typedef struct packed {
      logic        known;
      logic [5:0]  kind;
      logic [3:0]  operand_format;
      logic [4:0]  source_reg_s;
      logic [4:0]  source_reg_t;
      logic [4:0]  dest_reg_d;
      logic [4:0]  shift_amount;
      logic [15:0] immediate;
      logic [2:0]  coproc_select;
      logic [31:0] target_address;
      logic [5:0]  written_register;
      logic [1:0]  delay_slot_class;
   } rsp_type;

   // instruction kinds
   localparam logic [5:0] K_ADDU    = 6'd0;
   localparam logic [5:0] K_ADDIU   = 6'd1;
   localparam logic [5:0] K_AND     = 6'd2;
   localparam logic [5:0] K_ANDI    = 6'd3;
   localparam logic [5:0] K_BEQ     = 6'd4;
   localparam logic [5:0] K_BEQL    = 6'd5;
   localparam logic [5:0] K_BGEZ    = 6'd6;
   localparam logic [5:0] K_BGTZ    = 6'd7;
   localparam logic [5:0] K_BLEZ    = 6'd8;
   localparam logic [5:0] K_BLTZ    = 6'd9;
   localparam logic [5:0] K_BNE     = 6'd10;
   localparam logic [5:0] K_BNEL    = 6'd11;
   localparam logic [5:0] K_J       = 6'd12;
   localparam logic [5:0] K_JALR    = 6'd13;
   localparam logic [5:0] K_JR      = 6'd14;
   localparam logic [5:0] K_LB      = 6'd15;
   localparam logic [5:0] K_LBU     = 6'd16;
   localparam logic [5:0] K_LH      = 6'd17;
   localparam logic [5:0] K_LHU     = 6'd18;
   localparam logic [5:0] K_LUI     = 6'd19;
   localparam logic [5:0] K_LW      = 6'd20;
   localparam logic [5:0] K_LWL     = 6'd21;
   localparam logic [5:0] K_LWR     = 6'd22;
   localparam logic [5:0] K_MFC0    = 6'd23;
   localparam logic [5:0] K_MFHI    = 6'd24;
   localparam logic [5:0] K_MTC0    = 6'd25;
   localparam logic [5:0] K_MULT    = 6'd26;
   localparam logic [5:0] K_NOP     = 6'd27;
   localparam logic [5:0] K_OR      = 6'd28;
   localparam logic [5:0] K_ORI     = 6'd29;
   localparam logic [5:0] K_SB      = 6'd30;
   localparam logic [5:0] K_SH      = 6'd31;
   localparam logic [5:0] K_SLL     = 6'd32;
   localparam logic [5:0] K_SLTI    = 6'd33;
   localparam logic [5:0] K_SLTIU   = 6'd34;
   localparam logic [5:0] K_SLTU    = 6'd35;
   localparam logic [5:0] K_SRA     = 6'd36;
   localparam logic [5:0] K_SRL     = 6'd37;
   localparam logic [5:0] K_SSNOP   = 6'd38;
   localparam logic [5:0] K_SUBU    = 6'd39;
   localparam logic [5:0] K_SW      = 6'd40;
   localparam logic [5:0] K_SWL     = 6'd41;
   localparam logic [5:0] K_SWR     = 6'd42;
   localparam logic [5:0] K_XORI    = 6'd43;
   localparam logic [5:0] K_JALR_HB = 6'd44;
   localparam logic [5:0] K_JR_HB   = 6'd45;

   // operand formats
   localparam logic [3:0] F_NOARG   = 4'd0;
   localparam logic [3:0] F_RSRTRD  = 4'd1;
   localparam logic [3:0] F_RSRT    = 4'd2;
   localparam logic [3:0] F_RSRTSI  = 4'd3;
   localparam logic [3:0] F_RSSI    = 4'd4;
   localparam logic [3:0] F_RSRTUI  = 4'd5;
   localparam logic [3:0] F_RTUI    = 4'd6;
   localparam logic [3:0] F_RTRDSA  = 4'd7;
   localparam logic [3:0] F_RSRD    = 4'd8;
   localparam logic [3:0] F_RD      = 4'd9;
   localparam logic [3:0] F_RS      = 4'd10;
   localparam logic [3:0] F_RTRDSEL = 4'd11;

   // result field
   localparam logic [1:0] RES_NONE = 2'd0;
   localparam logic [1:0] RES_RD   = 2'd1;
   localparam logic [1:0] RES_RT   = 2'd2;

   // delay slot classes
   localparam logic [1:0] DS_NONE   = 2'd0;
   localparam logic [1:0] DS_ALWAYS = 2'd1;
   localparam logic [1:0] DS_LIKELY = 2'd2;

   localparam logic [5:0] NO_REG = 6'd32;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_COP0    = 6'h10;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BEQL    = 6'h14;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BNEL    = 6'h15;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LWL     = 6'h22;
   localparam logic [5:0] OP_LWR     = 6'h26;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_SLTIU   = 6'h0B;
   localparam logic [5:0] OP_SW      = 6'h2B;
   localparam logic [5:0] OP_SWL     = 6'h2A;
   localparam logic [5:0] OP_SWR     = 6'h2E;
   localparam logic [5:0] OP_XORI    = 6'h0E;

   // special function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_JALR = 6'h09;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_SLTU = 6'h2B;

   // regimm rt and cop0 rs codes
   localparam logic [4:0] RI_BLTZ = 5'h00;
   localparam logic [4:0] RI_BGEZ = 5'h01;
   localparam logic [4:0] C0_MF   = 5'h00;
   localparam logic [4:0] C0_MT   = 5'h04;

   // fields a format carries
   typedef struct packed {
      logic rs;
      logic rt;
      logic rd;
      logic sa;
      logic imm;
      logic sel;
   } use_type;

   function automatic logic [3:0] kind_fmt(input logic [5:0] k);
      logic [3:0] f;
      unique case (k) inside
         K_ADDU, K_AND, K_OR, K_SLTU, K_SUBU: f = F_RSRTRD;
         K_ADDIU, K_BEQ, K_BEQL, K_BNE, K_BNEL, K_LB, K_LBU, K_LH, K_LHU,
         K_LW, K_LWL, K_LWR, K_SB, K_SH, K_SLTI, K_SLTIU, K_SW, K_SWL,
         K_SWR: f = F_RSRTSI;
         K_ANDI, K_ORI, K_XORI: f = F_RSRTUI;
         K_BGEZ, K_BGTZ, K_BLEZ, K_BLTZ: f = F_RSSI;
         K_JALR, K_JALR_HB: f = F_RSRD;
         K_JR, K_JR_HB: f = F_RS;
         K_LUI: f = F_RTUI;
         K_MFC0, K_MTC0: f = F_RTRDSEL;
         K_MFHI: f = F_RD;
         K_MULT: f = F_RSRT;
         K_SLL, K_SRA, K_SRL: f = F_RTRDSA;
         default: f = F_NOARG;
      endcase
      return f;
   endfunction

   function automatic logic [1:0] kind_res(input logic [5:0] k);
      logic [1:0] r;
      unique case (k) inside
         K_ADDU, K_AND, K_MFHI, K_OR, K_SLL, K_SLTU, K_SRA, K_SRL,
         K_SUBU: r = RES_RD;
         K_ADDIU, K_ANDI, K_LB, K_LBU, K_LH, K_LHU, K_LUI, K_LW, K_LWL,
         K_LWR, K_MFC0, K_ORI, K_SLTI, K_SLTIU, K_XORI: r = RES_RT;
         default: r = RES_NONE;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] kind_ds(input logic [5:0] k);
      logic [1:0] d;
      unique case (k) inside
         K_BEQ, K_BGEZ, K_BGTZ, K_BLEZ, K_BLTZ, K_BNE, K_J, K_JALR, K_JR,
         K_JALR_HB, K_JR_HB: d = DS_ALWAYS;
         K_BEQL, K_BNEL: d = DS_LIKELY;
         default: d = DS_NONE;
      endcase
      return d;
   endfunction

   function automatic use_type fmt_use(input logic [3:0] f);
      use_type u;
      u = '0;
      unique case (f)
         F_RSRTRD:  begin u.rs = 1'b1; u.rt = 1'b1; u.rd = 1'b1; end
         F_RSRT:    begin u.rs = 1'b1; u.rt = 1'b1; end
         F_RSRTSI:  begin u.rs = 1'b1; u.rt = 1'b1; u.imm = 1'b1; end
         F_RSSI:    begin u.rs = 1'b1; u.imm = 1'b1; end
         F_RSRTUI:  begin u.rs = 1'b1; u.rt = 1'b1; u.imm = 1'b1; end
         F_RTUI:    begin u.rt = 1'b1; u.imm = 1'b1; end
         F_RTRDSA:  begin u.rt = 1'b1; u.rd = 1'b1; u.sa = 1'b1; end
         F_RSRD:    begin u.rs = 1'b1; u.rd = 1'b1; end
         F_RD:      begin u.rd = 1'b1; end
         F_RS:      begin u.rs = 1'b1; end
         F_RTRDSEL: begin u.rt = 1'b1; u.rd = 1'b1; u.sel = 1'b1; end
         default:   u = '0;
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

/* design/rifd_decode.sv */
// ----------------------------------------------------------------------------
// rifd_decode
// Combinational decode of one instruction word into kind, fields and target.
// ----------------------------------------------------------------------------
`default_nettype none

module rifd_decode (
   input  rifd_pkg::req_type req_in,
   output rifd_pkg::rsp_type rsp_out
);
   import rifd_pkg::*;

   logic [31:0] w;
   logic [31:0] pc4;
   logic [5:0]  opc;
   logic [5:0]  fn;
   logic [4:0]  rs;
   logic [4:0]  rt;
   logic [4:0]  rd;
   logic [4:0]  sa;
   logic        found;
   logic [5:0]  raw_kind;
   logic [5:0]  kind;
   logic [3:0]  fmt;
   logic [1:0]  res;
   use_type     use_f;
   logic [31:0] branch_tgt;
   logic [31:0] jump_tgt;

   assign w   = req_in.instruction_word;
   assign pc4 = req_in.instruction_address + 32'd4;
   assign opc = w[31:26];
   assign fn  = w[5:0];
   assign rs  = w[25:21];
   assign rt  = w[20:16];
   assign rd  = w[15:11];
   assign sa  = w[10:6];

   assign branch_tgt = pc4 + {{14{w[15]}}, w[15:0], 2'b00};
   assign jump_tgt   = {pc4[31:28], w[25:0], 2'b00};

   always_comb begin
      found    = 1'b1;
      raw_kind = K_ADDU;
      unique case (opc)
         OP_SPECIAL: begin
            unique case (fn)
               FN_ADDU: raw_kind = K_ADDU;
               FN_AND:  raw_kind = K_AND;
               FN_JALR: raw_kind = K_JALR;
               FN_JR:   raw_kind = K_JR;
               FN_MFHI: raw_kind = K_MFHI;
               FN_MULT: raw_kind = K_MULT;
               FN_OR:   raw_kind = K_OR;
               FN_SLL:  raw_kind = K_SLL;
               FN_SLTU: raw_kind = K_SLTU;
               FN_SRA:  raw_kind = K_SRA;
               FN_SRL:  raw_kind = K_SRL;
               FN_SUBU: raw_kind = K_SUBU;
               default: found = 1'b0;
            endcase
         end
         OP_REGIMM: begin
            unique case (rt)
               RI_BGEZ: raw_kind = K_BGEZ;
               RI_BLTZ: raw_kind = K_BLTZ;
               default: found = 1'b0;
            endcase
         end
         OP_COP0: begin
            unique case (rs)
               C0_MF:   raw_kind = K_MFC0;
               C0_MT:   raw_kind = K_MTC0;
               default: found = 1'b0;
            endcase
         end
         OP_ADDIU: raw_kind = K_ADDIU;
         OP_ANDI:  raw_kind = K_ANDI;
         OP_BEQ:   raw_kind = K_BEQ;
         OP_BEQL:  raw_kind = K_BEQL;
         OP_BGTZ:  raw_kind = K_BGTZ;
         OP_BLEZ:  raw_kind = K_BLEZ;
         OP_BNE:   raw_kind = K_BNE;
         OP_BNEL:  raw_kind = K_BNEL;
         OP_J:     raw_kind = K_J;
         OP_LB:    raw_kind = K_LB;
         OP_LBU:   raw_kind = K_LBU;
         OP_LH:    raw_kind = K_LH;
         OP_LHU:   raw_kind = K_LHU;
         OP_LUI:   raw_kind = K_LUI;
         OP_LW:    raw_kind = K_LW;
         OP_LWL:   raw_kind = K_LWL;
         OP_LWR:   raw_kind = K_LWR;
         OP_ORI:   raw_kind = K_ORI;
         OP_SB:    raw_kind = K_SB;
         OP_SH:    raw_kind = K_SH;
         OP_SLTI:  raw_kind = K_SLTI;
         OP_SLTIU: raw_kind = K_SLTIU;
         OP_SW:    raw_kind = K_SW;
         OP_SWL:   raw_kind = K_SWL;
         OP_SWR:   raw_kind = K_SWR;
         OP_XORI:  raw_kind = K_XORI;
         default:  found = 1'b0;
      endcase
   end

   always_comb begin
      kind = raw_kind;
      // hazard barrier forms, then the nop and ssnop forms of sll
      if (raw_kind == K_JALR && w[10]) begin
         kind = K_JALR_HB;
      end else if (raw_kind == K_JR && w[10]) begin
         kind = K_JR_HB;
      end else if (raw_kind == K_SLL && rt == 5'd0 && rd == 5'd0 && sa[4:1] == 4'd0) begin
         kind = sa[0] ? K_SSNOP : K_NOP;
      end
   end

   assign fmt   = kind_fmt(kind);
   assign res   = kind_res(kind);
   assign use_f = fmt_use(fmt);

   always_comb begin
      rsp_out = '0;
      rsp_out.written_register = NO_REG;
      if (found) begin
         rsp_out.known            = 1'b1;
         rsp_out.kind             = kind;
         rsp_out.operand_format   = fmt;
         rsp_out.source_reg_s     = use_f.rs  ? rs : 5'd0;
         rsp_out.source_reg_t     = use_f.rt  ? rt : 5'd0;
         rsp_out.dest_reg_d       = use_f.rd  ? rd : 5'd0;
         rsp_out.shift_amount     = use_f.sa  ? sa : 5'd0;
         rsp_out.immediate        = use_f.imm ? w[15:0] : 16'd0;
         rsp_out.coproc_select    = use_f.sel ? w[2:0] : 3'd0;
         rsp_out.delay_slot_class = kind_ds(kind);
         if (kind >= K_BEQ && kind <= K_BNEL) begin
            rsp_out.target_address = branch_tgt;
         end else if (kind == K_J) begin
            rsp_out.target_address = jump_tgt;
         end
         if (res == RES_RD) begin
            rsp_out.written_register = {1'b0, rsp_out.dest_reg_d};
         end else if (res == RES_RT) begin
            rsp_out.written_register = {1'b0, rsp_out.source_reg_t};
         end
      end
   end

endmodule

`default_nettype wire

/* design/risc_instruction_field_decoder.sv */
// ----------------------------------------------------------------------------
// risc_instruction_field_decoder
// Decodes one instruction word per transaction into kind, operand fields,
// written register, delay slot class and branch or jump target.
// ----------------------------------------------------------------------------
// path: a request passes through the input register, the decode logic and the
//    result register before rsp_valid rises
// throughput: one transaction per cycle while rsp_stall is low
// reset: synchronous, clears both valid flags; no other state
// ----------------------------------------------------------------------------
`default_nettype none

module risc_instruction_field_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rifd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rifd_pkg::rsp_type rsp_data
);
   import rifd_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    out_free;
   logic    in_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;

   rifd_decode u_decode (
      .req_in  (in_data_ff),
      .rsp_out (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_free) begin
         in_data_ff <= req_data;
      end
      if (out_free) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* dv/risc_instruction_field_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// risc_instruction_field_decoder_tb
// Sends instruction words with their addresses through the valid/stall
// request channel and checks every decoded result against an in-bench
// decoder, in order. Covers directed corner words and every instruction kind.
// Random streams run under changing sender and receiver idling, and one long
// receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------

module risc_instruction_field_decoder_tb;
   import rifd_pkg::*;

   typedef struct packed {
      req_type request;
      rsp_type decode;
   } decode_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   decode_entry_type expected_decodes[$];
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_request = 0;
   int unsigned hold_left = 0;

   risc_instruction_field_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] enc_r(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [4:0] rd,
                                         input logic [4:0] sa, input logic [5:0] fn);
      return {op, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic rsp_type decode_instruction(input logic [31:0] w, input logic [31:0] a);
      rsp_type    r;
      logic       found;
      logic [5:0] k;
      logic [3:0] fmt;
      logic [4:0] rs, rt, rd, sa;
      logic [31:0] next_pc;
      logic       has_rs, has_rt, has_rd, has_sa, has_imm, has_sel;
      r = '0;
      found = 1'b1;
      k = K_ADDU;
      case (w[31:26])
         OP_SPECIAL: begin
            case (w[5:0])
               FN_ADDU: k = K_ADDU;
               FN_AND:  k = K_AND;
               FN_JALR: k = K_JALR;
               FN_JR:   k = K_JR;
               FN_MFHI: k = K_MFHI;
               FN_MULT: k = K_MULT;
               FN_OR:   k = K_OR;
               FN_SLL:  k = K_SLL;
               FN_SLTU: k = K_SLTU;
               FN_SRA:  k = K_SRA;
               FN_SRL:  k = K_SRL;
               FN_SUBU: k = K_SUBU;
               default: found = 1'b0;
            endcase
         end
         OP_REGIMM: begin
            case (w[20:16])
               RI_BGEZ: k = K_BGEZ;
               RI_BLTZ: k = K_BLTZ;
               default: found = 1'b0;
            endcase
         end
         OP_COP0: begin
            case (w[25:21])
               C0_MF:   k = K_MFC0;
               C0_MT:   k = K_MTC0;
               default: found = 1'b0;
            endcase
         end
         OP_ADDIU: k = K_ADDIU;
         OP_ANDI:  k = K_ANDI;
         OP_BEQ:   k = K_BEQ;
         OP_BEQL:  k = K_BEQL;
         OP_BGTZ:  k = K_BGTZ;
         OP_BLEZ:  k = K_BLEZ;
         OP_BNE:   k = K_BNE;
         OP_BNEL:  k = K_BNEL;
         OP_J:     k = K_J;
         OP_LB:    k = K_LB;
         OP_LBU:   k = K_LBU;
         OP_LH:    k = K_LH;
         OP_LHU:   k = K_LHU;
         OP_LUI:   k = K_LUI;
         OP_LW:    k = K_LW;
         OP_LWL:   k = K_LWL;
         OP_LWR:   k = K_LWR;
         OP_ORI:   k = K_ORI;
         OP_SB:    k = K_SB;
         OP_SH:    k = K_SH;
         OP_SLTI:  k = K_SLTI;
         OP_SLTIU: k = K_SLTIU;
         OP_SW:    k = K_SW;
         OP_SWL:   k = K_SWL;
         OP_SWR:   k = K_SWR;
         OP_XORI:  k = K_XORI;
         default:  found = 1'b0;
      endcase
      if (!found) begin
         r.written_register = NO_REG;
         return r;
      end
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sa = w[10:6];
      if (w[10] && k == K_JALR)
         k = K_JALR_HB;
      else if (w[10] && k == K_JR)
         k = K_JR_HB;
      if (k == K_SLL && rt == 5'd0 && rd == 5'd0 && sa <= 5'd1)
         k = (sa == 5'd0) ? K_NOP : K_SSNOP;

      case (k)
         K_ADDU, K_AND, K_OR, K_SLTU, K_SUBU: fmt = F_RSRTRD;
         K_ADDIU, K_BEQ, K_BEQL, K_BNE, K_BNEL, K_LB, K_LBU, K_LH, K_LHU, K_LW,
         K_LWL, K_LWR, K_SB, K_SH, K_SLTI, K_SLTIU, K_SW, K_SWL, K_SWR: fmt = F_RSRTSI;
         K_ANDI, K_ORI, K_XORI: fmt = F_RSRTUI;
         K_BGEZ, K_BGTZ, K_BLEZ, K_BLTZ: fmt = F_RSSI;
         K_JALR, K_JALR_HB: fmt = F_RSRD;
         K_JR, K_JR_HB: fmt = F_RS;
         K_LUI: fmt = F_RTUI;
         K_MFC0, K_MTC0: fmt = F_RTRDSEL;
         K_MFHI: fmt = F_RD;
         K_MULT: fmt = F_RSRT;
         K_SLL, K_SRA, K_SRL: fmt = F_RTRDSA;
         default: fmt = F_NOARG;
      endcase

      has_rs  = fmt == F_RSRTRD || fmt == F_RSRT || fmt == F_RSRTSI || fmt == F_RSSI ||
                fmt == F_RSRTUI || fmt == F_RSRD || fmt == F_RS;
      has_rt  = fmt == F_RSRTRD || fmt == F_RSRT || fmt == F_RSRTSI || fmt == F_RSRTUI ||
                fmt == F_RTUI || fmt == F_RTRDSA || fmt == F_RTRDSEL;
      has_rd  = fmt == F_RSRTRD || fmt == F_RTRDSA || fmt == F_RSRD || fmt == F_RD ||
                fmt == F_RTRDSEL;
      has_sa  = fmt == F_RTRDSA;
      has_imm = fmt == F_RSRTSI || fmt == F_RSSI || fmt == F_RSRTUI || fmt == F_RTUI;
      has_sel = fmt == F_RTRDSEL;

      r.known          = 1'b1;
      r.kind           = k;
      r.operand_format = fmt;
      r.source_reg_s   = has_rs ? rs : 5'd0;
      r.source_reg_t   = has_rt ? rt : 5'd0;
      r.dest_reg_d     = has_rd ? rd : 5'd0;
      r.shift_amount   = has_sa ? sa : 5'd0;
      r.immediate      = has_imm ? w[15:0] : 16'd0;
      r.coproc_select  = has_sel ? w[2:0] : 3'd0;

      next_pc = a + 32'd4;
      case (k)
         K_BEQ, K_BEQL, K_BGEZ, K_BGTZ, K_BLEZ, K_BLTZ, K_BNE, K_BNEL:
            r.target_address = next_pc + {{14{w[15]}}, w[15:0], 2'b00};
         K_J: r.target_address = {next_pc[31:28], w[25:0], 2'b00};
         default: r.target_address = 32'd0;
      endcase

      case (k)
         K_ADDU, K_AND, K_MFHI, K_OR, K_SLL, K_SLTU, K_SRA, K_SRL, K_SUBU:
            r.written_register = {1'b0, r.dest_reg_d};
         K_ADDIU, K_ANDI, K_LB, K_LBU, K_LH, K_LHU, K_LUI, K_LW, K_LWL, K_LWR, K_MFC0,
         K_ORI, K_SLTI, K_SLTIU, K_XORI:
            r.written_register = {1'b0, r.source_reg_t};
         default: r.written_register = NO_REG;
      endcase

      case (k)
         K_BEQ, K_BGEZ, K_BGTZ, K_BLEZ, K_BLTZ, K_BNE, K_J, K_JALR, K_JR, K_JALR_HB,
         K_JR_HB: r.delay_slot_class = DS_ALWAYS;
         K_BEQL, K_BNEL: r.delay_slot_class = DS_LIKELY;
         default: r.delay_slot_class = DS_NONE;
      endcase
      return r;
   endfunction

   function automatic string decode_text(input rsp_type d);
      return {$sformatf("known %0d kind %0d fmt %0d rs %0d rt %0d rd %0d sa %0d ",
                        d.known, d.kind, d.operand_format, d.source_reg_s,
                        d.source_reg_t, d.dest_reg_d, d.shift_amount),
              $sformatf("imm %h sel %0d tgt %h wr %0d ds %0d",
                        d.immediate, d.coproc_select, d.target_address,
                        d.written_register, d.delay_slot_class)};
   endfunction

   function automatic string differing_fields(input rsp_type e, input rsp_type a);
      string s;
      s = "";
      if (a.known !== e.known) s = {s, " known"};
      if (a.kind !== e.kind) s = {s, " kind"};
      if (a.operand_format !== e.operand_format) s = {s, " operand_format"};
      if (a.source_reg_s !== e.source_reg_s) s = {s, " source_reg_s"};
      if (a.source_reg_t !== e.source_reg_t) s = {s, " source_reg_t"};
      if (a.dest_reg_d !== e.dest_reg_d) s = {s, " dest_reg_d"};
      if (a.shift_amount !== e.shift_amount) s = {s, " shift_amount"};
      if (a.immediate !== e.immediate) s = {s, " immediate"};
      if (a.coproc_select !== e.coproc_select) s = {s, " coproc_select"};
      if (a.target_address !== e.target_address) s = {s, " target_address"};
      if (a.written_register !== e.written_register) s = {s, " written_register"};
      if (a.delay_slot_class !== e.delay_slot_class) s = {s, " delay_slot_class"};
      return s;
   endfunction

   task automatic check_decode(input rsp_type actual);
      decode_entry_type entry;
      string            diffs;
      if (expected_decodes.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected transaction: %s", decode_text(actual));
         return;
      end
      entry = expected_decodes.pop_front();
      diffs = differing_fields(entry.decode, actual);
      if (diffs != "") begin
         error_count++;
         if (error_count <= 10) begin
            $display("decode mismatch word %h addr %h:%s", entry.request.instruction_word,
                     entry.request.instruction_address, diffs);
            $display("  expected %s", decode_text(entry.decode));
            $display("  actual   %s", decode_text(actual));
         end
      end
   endtask

   // result side: check, then choose the stall for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_decode(rsp_data);
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic send_instruction(input logic [31:0] word, input logic [31:0] addr);
      req_type item;
      item.instruction_word = word;
      item.instruction_address = addr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_decodes.push_back({item, decode_instruction(word, addr)});
   endtask

   function automatic logic [5:0] special_fn(input int unsigned i);
      case (i)
         0:  return FN_ADDU;
         1:  return FN_AND;
         2:  return FN_JALR;
         3:  return FN_JR;
         4:  return FN_MFHI;
         5:  return FN_MULT;
         6:  return FN_OR;
         7:  return FN_SLL;
         8:  return FN_SLTU;
         9:  return FN_SRA;
         10: return FN_SRL;
         default: return FN_SUBU;
      endcase
   endfunction

   function automatic logic [5:0] primary_op(input int unsigned i);
      case (i)
         0:  return OP_ADDIU;
         1:  return OP_ANDI;
         2:  return OP_BEQ;
         3:  return OP_BEQL;
         4:  return OP_BGTZ;
         5:  return OP_BLEZ;
         6:  return OP_BNE;
         7:  return OP_BNEL;
         8:  return OP_J;
         9:  return OP_LB;
         10: return OP_LBU;
         11: return OP_LH;
         12: return OP_LHU;
         13: return OP_LUI;
         14: return OP_LW;
         15: return OP_LWL;
         16: return OP_LWR;
         17: return OP_ORI;
         18: return OP_SB;
         19: return OP_SH;
         20: return OP_SLTI;
         21: return OP_SLTIU;
         22: return OP_SW;
         23: return OP_SWL;
         24: return OP_SWR;
         default: return OP_XORI;
      endcase
   endfunction

   // index 0..41: special functions, regimm, cop0, then primary opcodes
   function automatic logic [31:0] word_for_kind(input int unsigned pick);
      logic [31:0] w;
      w = $urandom;
      if (pick < 12) begin
         w[31:26] = OP_SPECIAL;
         w[5:0] = special_fn(pick);
         if (w[5:0] == FN_SLL && $urandom_range(2) == 0) begin
            w[20:11] = '0;
            w[10:6] = 5'($urandom_range(2));
         end
      end else if (pick < 14) begin
         w[31:26] = OP_REGIMM;
         w[20:16] = (pick == 12) ? RI_BLTZ : RI_BGEZ;
      end else if (pick < 16) begin
         w[31:26] = OP_COP0;
         w[25:21] = (pick == 14) ? C0_MF : C0_MT;
      end else begin
         w[31:26] = primary_op(pick - 16);
      end
      return w;
   endfunction

   task automatic test_special_cases();
      send_instruction(32'h0000_0000, 32'h0000_0000);
      send_instruction(enc_r(OP_SPECIAL, 5'd31, 5'd0, 5'd0, 5'd1, FN_SLL), 32'hFFFF_FFFF);
      send_instruction(enc_r(OP_SPECIAL, 5'd0, 5'd0, 5'd0, 5'd2, FN_SLL), 32'h0000_0004);
      send_instruction(enc_r(OP_SPECIAL, 5'd0, 5'd0, 5'd5, 5'd0, FN_SLL), 32'h0000_0008);
      send_instruction(enc_r(OP_SPECIAL, 5'd31, 5'd0, 5'd0, 5'b10000, FN_JR), 32'h1000_0000);
      send_instruction(enc_r(OP_SPECIAL, 5'd7, 5'd0, 5'd31, 5'b10000, FN_JALR), 32'h2000_0000);
      send_instruction(enc_r(OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'b01111, FN_JR), 32'h3000_0000);
      send_instruction(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_instruction(enc_r(OP_SPECIAL, 5'd1, 5'd2, 5'd3, 5'd4, 6'h01), 32'h0000_0010);
      send_instruction(enc_i(OP_REGIMM, 5'd5, 5'h02, 16'h1234), 32'h0000_0014);
      send_instruction(enc_i(OP_COP0, 5'h01, 5'd3, 16'h4801), 32'h0000_0018);
      send_instruction(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0000_0000);
      send_instruction(enc_i(OP_BNE, 5'd31, 5'd31, 16'h7FFF), 32'hFFFF_FFFC);
      send_instruction(enc_i(OP_REGIMM, 5'd9, RI_BGEZ, 16'hFFFF), 32'h0000_0100);
      send_instruction(enc_i(OP_BLEZ, 5'd9, 5'd17, 16'h0001), 32'h8000_0000);
      send_instruction({OP_J, 26'h3FF_FFFF}, 32'hFFFF_FFFC);
      send_instruction({OP_J, 26'h000_0000}, 32'h8FFF_FFF0);
      send_instruction(enc_i(OP_ANDI, 5'd31, 5'd31, 16'hFFFF), 32'h7FFF_FFFF);
      send_instruction(enc_r(OP_COP0, C0_MF, 5'd31, 5'd31, 5'd0, 6'h07), 32'h0000_0020);
      send_instruction(enc_r(OP_COP0, C0_MT, 5'd4, 5'd12, 5'd0, 6'h00), 32'h0000_0024);
      send_instruction(enc_i(OP_LUI, 5'd31, 5'd8, 16'hABCD), 32'h0000_0028);
      send_instruction(enc_r(OP_SPECIAL, 5'd31, 5'd16, 5'd17, 5'd31, FN_SRA), 32'h0000_002C);
      send_instruction(enc_r(OP_SPECIAL, 5'd31, 5'd31, 5'd1, 5'd31, FN_MFHI), 32'h0000_0030);
   endtask

   task automatic test_every_kind();
      for (int unsigned i = 0; i < 42; i++)
         send_instruction(word_for_kind(i), $urandom);
   endtask

   task automatic test_random_stream(input int unsigned count);
      logic [31:0] word, addr;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15)
            word = $urandom;
         else
            word = word_for_kind($urandom_range(41));
         addr = $urandom;
         case ($urandom_range(9))
            0: addr[31:8] = '1;
            1: addr[31:8] = '0;
            2: addr[27:8] = '1;
            default: ;
         endcase
         send_instruction(word, addr);
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall requests
   task automatic test_backpressure();
      hold_request = 80;
      for (int unsigned i = 0; i < 24; i++)
         send_instruction(word_for_kind($urandom_range(41)), $urandom);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 31;
      recv_stall_pct = 72;
      test_special_cases();
      test_every_kind();
      test_random_stream(150);
      send_idle_pct = 72;
      recv_stall_pct = 31;
      test_random_stream(150);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();
      test_random_stream(150);
      req_valid <= 1'b0;
      wait (expected_decodes.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #1ms;
      $display("timeout with %0d transactions outstanding", expected_decodes.size());
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
design/rifd_pkg.sv
design/rifd_decode.sv
design/risc_instruction_field_decoder.sv
dv/risc_instruction_field_decoder_tb.sv
